/* hdl/fcm_pkg.sv */
// ----------------------------------------------------------------------------
// fcm_pkg
// Types and codes shared by the frame and control mailbox modules.
// ----------------------------------------------------------------------------
package fcm_pkg;

	// command codes
	localparam logic [2:0] CMD_PUBLISH = 3'd0;
	localparam logic [2:0] CMD_ENQUEUE = 3'd1;
	localparam logic [2:0] CMD_TAKE    = 3'd2;
	localparam logic [2:0] CMD_CAPTURE = 3'd3;
	localparam logic [2:0] CMD_ACK     = 3'd4;
	localparam logic [2:0] CMD_CLOSE   = 3'd5;

	// status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_CLOSED  = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_EMPTY   = 3'd4;

	localparam logic [12:0] FRAME_MAX = 13'd4096;

	typedef struct packed {
		logic [2:0]  command;
		logic [15:0] surface_id;
		logic [12:0] surface_width;
		logic [12:0] surface_height;
		logic [15:0] surface_stride;
		logic [31:0] palette_tag;
		logic [11:0] dirty_left_in;
		logic [11:0] dirty_top_in;
		logic [11:0] dirty_right_in;
		logic [11:0] dirty_bottom_in;
		logic [31:0] control_in;
		logic [31:0] ack_generation;
	} fcm_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] generation_out;
		logic [15:0] surface_id_out;
		logic [12:0] width_out;
		logic [12:0] height_out;
		logic [15:0] stride_out;
		logic [11:0] dirty_left_out;
		logic [11:0] dirty_top_out;
		logic [11:0] dirty_right_out;
		logic [11:0] dirty_bottom_out;
		logic [31:0] control_out;
	} fcm_rsp_t;

	// controller to datapath
	typedef struct packed {
		logic exec;      // apply the accepted request
		logic load_ctl;  // move ring read data into the response
	} fcm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic take_hit;  // request is a take that finds a word
	} fcm_stat_t;

endpackage

/* hdl/fcm_req_if.sv */
// ----------------------------------------------------------------------------
// fcm_req_if
// Request channel: valid/ready handshake with a mailbox request payload.
// ----------------------------------------------------------------------------
interface fcm_req_if;
	import fcm_pkg::*;

	logic     valid;
	logic     ready;
	fcm_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hdl/fcm_rsp_if.sv */
// ----------------------------------------------------------------------------
// fcm_rsp_if
// Response channel: valid/ready handshake with a mailbox response payload.
// ----------------------------------------------------------------------------
interface fcm_rsp_if;
	import fcm_pkg::*;

	logic     valid;
	logic     ready;
	fcm_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hdl/fcm_ram.sv */
// ----------------------------------------------------------------------------
// fcm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fcm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

/* hdl/fcm_ctrl.sv */
// ----------------------------------------------------------------------------
// fcm_ctrl
// Mailbox controller: request/response handshake and the ring read wait.
// ----------------------------------------------------------------------------
module fcm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  fcm_pkg::fcm_stat_t stat,
	output fcm_pkg::fcm_cmd_t  cmd
);
	import fcm_pkg::*;

	localparam logic [0:0] S_IDLE = 1'b0;
	localparam logic [0:0] S_READ = 1'b1;

	logic [0:0] state_q;
	logic [0:0] state_n;
	logic       rsp_valid_q;
	logic       accept;
	logic       rsp_load;

	// accept while the response register is free or drains this cycle
	assign in_ready  = (state_q == S_IDLE) && (!rsp_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = rsp_valid_q;

	assign cmd.exec     = accept;
	assign cmd.load_ctl = (state_q == S_READ);

	assign rsp_load = (accept && !stat.take_hit) || (state_q == S_READ);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && stat.take_hit) begin
					state_n = S_READ;
				end
			end
			S_READ: begin
				state_n = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (out_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end
endmodule

/* hdl/fcm_dp.sv */
// ----------------------------------------------------------------------------
// fcm_dp
// Mailbox datapath: frame state, dirty rectangle merge, control ring and
// the response register.
// ----------------------------------------------------------------------------
module fcm_dp #(
	parameter int QUEUE_LIMIT = 15,
	parameter int RING_DEPTH  = 16,
	parameter int STOP_CODE   = 0,
	parameter int MAX_CODE    = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fcm_pkg::fcm_req_t  req,
	input  fcm_pkg::fcm_cmd_t  cmd,
	output fcm_pkg::fcm_stat_t stat,
	output fcm_pkg::fcm_rsp_t  rsp
);
	import fcm_pkg::*;

	localparam int AW = $clog2(RING_DEPTH);
	localparam int CW = $clog2(RING_DEPTH + 1);
	localparam logic [3:0] STOP_KIND = 4'(STOP_CODE);
	localparam logic [3:0] MAX_KIND  = 4'(MAX_CODE);

	logic        closed_q;
	logic        pending_q;
	logic [31:0] gen_q;
	logic [15:0] surf_q;
	logic [12:0] width_q;
	logic [12:0] height_q;
	logic [15:0] stride_q;
	logic [31:0] pal_q;
	logic [11:0] left_q;
	logic [11:0] top_q;
	logic [11:0] right_q;
	logic [11:0] bottom_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	fcm_rsp_t      rsp_q;

	fcm_rsp_t    rsp_n;
	logic        pub_ok;
	logic        push;
	logic        pop;
	logic        set_closed;
	logic        clr_pending;
	logic        sid_nz;
	logic        geo_bad;
	logic        rect_bad;
	logic        pub_bad;
	logic        full_redraw;
	logic [11:0] l_n;
	logic [11:0] t_n;
	logic [11:0] r_n;
	logic [11:0] b_n;
	logic [3:0]  kind;
	logic        ring_phys_full;
	logic        queue_full;
	logic [AW:0] tail_sum;
	logic [AW-1:0] tail;
	logic [31:0] ram_rdata;

	// frame checks
	assign sid_nz   = req.surface_id != 16'd0;
	assign geo_bad  = (req.surface_width == 13'd0) || (req.surface_width > FRAME_MAX) ||
			(req.surface_height == 13'd0) || (req.surface_height > FRAME_MAX);
	assign rect_bad = (req.dirty_left_in > req.dirty_right_in) ||
			(req.dirty_top_in > req.dirty_bottom_in) ||
			({1'b0, req.dirty_right_in} >= req.surface_width) ||
			({1'b0, req.dirty_bottom_in} >= req.surface_height);
	assign pub_bad  = sid_nz && (geo_bad || rect_bad);

	assign full_redraw = (gen_q == 32'd0) || (surf_q != req.surface_id) ||
			(width_q != req.surface_width) || (height_q != req.surface_height) ||
			(stride_q != req.surface_stride) || (pal_q != req.palette_tag);

	always_comb begin
		l_n = req.dirty_left_in;
		t_n = req.dirty_top_in;
		r_n = req.dirty_right_in;
		b_n = req.dirty_bottom_in;
		if (sid_nz && full_redraw) begin
			l_n = 12'd0;
			t_n = 12'd0;
			r_n = 12'(req.surface_width - 13'd1);
			b_n = 12'(req.surface_height - 13'd1);
		end else if (sid_nz && pending_q) begin
			// bounding box with the pending rectangle
			if (left_q < req.dirty_left_in) l_n = left_q;
			if (top_q < req.dirty_top_in) t_n = top_q;
			if (right_q > req.dirty_right_in) r_n = right_q;
			if (bottom_q > req.dirty_bottom_in) b_n = bottom_q;
		end
	end

	// ring occupancy
	assign kind           = req.control_in[3:0];
	assign ring_phys_full = count_q == CW'(RING_DEPTH);
	assign queue_full     = ring_phys_full || (int'(count_q) >= QUEUE_LIMIT);

	always_comb begin
		tail_sum = (AW+1)'(head_q) + (AW+1)'(count_q);
		if (tail_sum >= (AW+1)'(RING_DEPTH)) begin
			tail_sum = tail_sum - (AW+1)'(RING_DEPTH);
		end
		tail = tail_sum[AW-1:0];
	end

	assign stat.take_hit = (req.command == CMD_TAKE) && (count_q != '0);

	always_comb begin
		rsp_n       = '0;
		pub_ok      = 1'b0;
		push        = 1'b0;
		pop         = 1'b0;
		set_closed  = 1'b0;
		clr_pending = 1'b0;
		unique case (req.command)
			CMD_PUBLISH: begin
				if (pub_bad) begin
					rsp_n.status = ST_INVALID;
				end else if (closed_q) begin
					rsp_n.status = ST_CLOSED;
				end else begin
					pub_ok = 1'b1;
				end
			end
			CMD_ENQUEUE: begin
				if (kind > MAX_KIND) begin
					rsp_n.status = ST_INVALID;
				end else if (kind == STOP_KIND) begin
					// stop bypasses the queue limit; drop it if the mailbox is closed or the ring is full
					if (!closed_q) begin
						set_closed = 1'b1;
						push       = !ring_phys_full;
					end
				end else if (closed_q) begin
					rsp_n.status = ST_CLOSED;
				end else if (queue_full) begin
					rsp_n.status = ST_FULL;
				end else begin
					push = 1'b1;
				end
			end
			CMD_TAKE: begin
				if (count_q == '0) begin
					rsp_n.status = ST_EMPTY;
				end else begin
					pop = 1'b1;
				end
			end
			CMD_CAPTURE: begin
				if (!pending_q) begin
					rsp_n.status = ST_EMPTY;
				end else begin
					rsp_n.generation_out   = gen_q;
					rsp_n.surface_id_out   = surf_q;
					rsp_n.width_out        = width_q;
					rsp_n.height_out       = height_q;
					rsp_n.stride_out       = stride_q;
					rsp_n.dirty_left_out   = left_q;
					rsp_n.dirty_top_out    = top_q;
					rsp_n.dirty_right_out  = right_q;
					rsp_n.dirty_bottom_out = bottom_q;
				end
			end
			CMD_ACK: begin
				clr_pending = req.ack_generation == gen_q;
			end
			CMD_CLOSE: begin
				set_closed = 1'b1;
			end
			default: begin
				rsp_n.status = ST_INVALID;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closed_q  <= 1'b0;
			pending_q <= 1'b0;
			gen_q     <= '0;
			surf_q    <= '0;
			width_q   <= '0;
			height_q  <= '0;
			stride_q  <= '0;
			pal_q     <= '0;
			left_q    <= '0;
			top_q     <= '0;
			right_q   <= '0;
			bottom_q  <= '0;
			head_q    <= '0;
			count_q   <= '0;
		end else if (cmd.exec) begin
			if (set_closed) begin
				closed_q <= 1'b1;
			end
			if (pub_ok) begin
				pending_q <= 1'b1;
				gen_q     <= gen_q + 32'd1;
				surf_q    <= req.surface_id;
				width_q   <= req.surface_width;
				height_q  <= req.surface_height;
				stride_q  <= req.surface_stride;
				pal_q     <= req.palette_tag;
				left_q    <= l_n;
				top_q     <= t_n;
				right_q   <= r_n;
				bottom_q  <= b_n;
			end else if (clr_pending) begin
				pending_q <= 1'b0;
			end
			if (push) begin
				count_q <= count_q + CW'(1);
			end else if (pop) begin
				count_q <= count_q - CW'(1);
				head_q  <= (head_q == AW'(RING_DEPTH - 1)) ? '0 : head_q + AW'(1);
			end
		end
	end

	// response register; the ring word is loaded in the cycle after a take
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rsp_q <= rsp_n;
		end else if (cmd.load_ctl) begin
			rsp_q.control_out <= ram_rdata;
		end
	end

	assign rsp = rsp_q;

	fcm_ram #(
		.WIDTH(32),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (cmd.exec && push),
		.waddr (tail),
		.wdata (req.control_in),
		.re    (cmd.exec && pop),
		.raddr (head_q),
		.rdata (ram_rdata)
	);
endmodule

/* hdl/frame_and_control_mailbox_core.sv */
// ----------------------------------------------------------------------------
// frame_and_control_mailbox_core
// Frame mailbox with dirty rectangle merge and a ring of control words.
// ----------------------------------------------------------------------------
//  channel | dir | payload   | notes
//  req     | in  | fcm_req_t | one request per command
//  rsp     | out | fcm_rsp_t | one response per request, in order
//
// A take that finds a word passes through the read state, which loads the
// registered read of the ring RAM into the response.
// Responses sit in an output register; a new request is accepted while that
// register is empty or being drained in the same cycle.
// Reset clears flags, generation, stored frame and ring pointers; ring
// contents stay undefined and are never read before being written.
// ----------------------------------------------------------------------------
module frame_and_control_mailbox_core #(
	parameter int QUEUE_LIMIT = 15,
	parameter int RING_DEPTH  = 16,
	parameter int STOP_CODE   = 0,
	parameter int MAX_CODE    = 7
) (
	input  logic     clk,
	input  logic     arst_n,
	fcm_req_if.sink  req,
	fcm_rsp_if.source rsp
);
	import fcm_pkg::*;

	fcm_cmd_t  cmd;
	fcm_stat_t stat;

	fcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	fcm_dp #(
		.QUEUE_LIMIT (QUEUE_LIMIT),
		.RING_DEPTH  (RING_DEPTH),
		.STOP_CODE   (STOP_CODE),
		.MAX_CODE    (MAX_CODE)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.data),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp.data)
	);
endmodule
